// ===== design/adbr_pkg.sv =====
package adbr_pkg;

  // Ring geometry
  localparam int RING_WORDS = 4096;
  localparam int RING_AW    = $clog2(RING_WORDS);

  // Field and register widths
  localparam int ADDR_W     = 24;
  localparam int LEN_W      = 18;
  localparam int WORD_W     = 32;
  localparam int FRAMES_W   = 13;
  localparam int CAP_W      = 15;
  localparam int CW_W       = CAP_W - 2;
  localparam int FILL_W     = 15;
  localparam int CNT_W      = 13;
  localparam int STEP_SH    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CAP_W-1:0] CAP_RESET = 15'd16384;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_ON       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AI_EMULATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd2;

  typedef enum logic [1:0] {
    MODE_LEN_WRITE = 2'd0,
    MODE_DMA_WORD  = 2'd1,
    MODE_PLAY      = 2'd2,
    MODE_LEN_READ  = 2'd3
  } mode_t;

  // Where the played sample of a result comes from
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_HELD = 2'd1,
    SRC_RING = 2'd2
  } sample_src_t;

  typedef struct packed {
    mode_t               mode;
    logic [ADDR_W-1:0]   dma_address;
    logic [LEN_W-1:0]    dma_length;
    logic [WORD_W-1:0]   dma_word;
    logic                request_first;
    logic [FRAMES_W-1:0] request_frames;
  } adbr_in_t;

  typedef struct packed {
    logic              ai_busy;
    logic              fifo_full;
    logic              interrupt;
    logic              fetch_valid;
    logic [ADDR_W-1:0] fetch_address;
    logic              word_taken;
    logic [WORD_W-1:0] play_sample;
    logic              underrun;
    logic [LEN_W-1:0]  length_readback;
  } adbr_out_t;

  // Result as it leaves the control logic, sample still to be resolved
  typedef struct packed {
    logic              ai_busy;
    logic              fifo_full;
    logic              interrupt;
    logic              fetch_valid;
    logic [ADDR_W-1:0] fetch_address;
    logic              word_taken;
    sample_src_t       src;
    logic              underrun;
    logic [LEN_W-1:0]  length_readback;
  } adbr_res_t;

  // Ring memory access for one word
  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } adbr_ram_req_t;

endpackage

// ===== design/adbr_ram.sv =====
module adbr_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/adbr_ctrl.sv =====
module adbr_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  adbr_pkg::adbr_in_t                 item,
  input  logic                               cfg_write,
  input  logic [adbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adbr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output adbr_pkg::adbr_ram_req_t            ram_req,
  output adbr_pkg::adbr_res_t                res
);

  // Configuration registers
  logic                         dma_on;
  logic                         ai_emulation;
  logic [adbr_pkg::CAP_W-1:0]   ring_capacity;

  // Descriptor, ring and tracker state
  logic [adbr_pkg::ADDR_W-1:0]  primary_address, primary_address_next;
  logic [adbr_pkg::LEN_W-1:0]   primary_bytes, primary_bytes_next;
  logic [adbr_pkg::ADDR_W-1:0]  secondary_address, secondary_address_next;
  logic [adbr_pkg::LEN_W-1:0]   secondary_bytes, secondary_bytes_next;
  logic [adbr_pkg::RING_AW-1:0] write_index, write_index_next;
  logic [adbr_pkg::RING_AW-1:0] read_index, read_index_next;
  logic [adbr_pkg::FILL_W-1:0]  fill_level, fill_level_next;
  logic [adbr_pkg::LEN_W-1:0]   previous_length, previous_length_next;
  logic [adbr_pkg::LEN_W-1:0]   tracked_length, tracked_length_next;
  logic [adbr_pkg::CNT_W-1:0]   tracked_count, tracked_count_next;
  logic                         request_granted, request_granted_next;
  logic                         status_busy, status_busy_next;
  logic                         status_full, status_full_next;

  // Working values
  logic [adbr_pkg::CW_W-1:0]    cap_words;
  logic [adbr_pkg::FILL_W-1:0]  cap_bytes;
  logic [adbr_pkg::RING_AW:0]   write_inc;
  logic [adbr_pkg::RING_AW:0]   read_inc;
  logic                         fetch_now;
  logic [adbr_pkg::FILL_W-1:0]  want_bytes;
  logic [adbr_pkg::LEN_W+1:0]   readback_limit;
  logic [adbr_pkg::LEN_W:0]     read_step;
  logic [adbr_pkg::LEN_W-1:0]   remain;

  // Capacity in words, clamped to one word .. the whole memory.
  always_comb begin
    cap_words = ring_capacity[adbr_pkg::CAP_W-1:2];
    if (cap_words == '0) begin
      cap_words = adbr_pkg::CW_W'(1);
    end
    if (cap_words > adbr_pkg::RING_WORDS) begin
      cap_words = adbr_pkg::CW_W'(adbr_pkg::RING_WORDS);
    end
  end

  assign cap_bytes = {cap_words, 2'b00};
  assign write_inc = {1'b0, write_index} + 1'b1;
  assign read_inc  = {1'b0, read_index} + 1'b1;
  assign fetch_now = dma_on && (fill_level < cap_bytes) && (primary_bytes != '0);
  assign want_bytes = {item.request_frames, 2'b00};
  assign readback_limit = {2'b00, previous_length} + {1'b0, previous_length, 1'b0}
                          - {2'b00, previous_length} + {4'b0, previous_length[17:2]};
  assign read_step = {({1'b0, tracked_count} + 1'b1), {adbr_pkg::STEP_SH{1'b0}}};

  // Next state and result for the word at the input.
  always_comb begin
    primary_address_next   = primary_address;
    primary_bytes_next     = primary_bytes;
    secondary_address_next = secondary_address;
    secondary_bytes_next   = secondary_bytes;
    write_index_next       = write_index;
    read_index_next        = read_index;
    fill_level_next        = fill_level;
    previous_length_next   = previous_length;
    tracked_length_next    = tracked_length;
    tracked_count_next     = tracked_count;
    request_granted_next   = request_granted;
    status_busy_next       = status_busy;
    status_full_next       = status_full;
    remain                 = '0;

    ram_req.we    = 1'b0;
    ram_req.waddr = write_index;
    ram_req.wdata = {item.dma_word[15:0], item.dma_word[31:16]};
    ram_req.re    = 1'b0;
    ram_req.raddr = read_index;

    res.interrupt       = 1'b0;
    res.word_taken      = 1'b0;
    res.src             = adbr_pkg::SRC_ZERO;
    res.underrun        = 1'b0;
    res.length_readback = '0;

    case (item.mode)
      adbr_pkg::MODE_LEN_WRITE: begin
        if (item.dma_length == '0) begin
          status_busy_next = 1'b0;
          status_full_next = 1'b0;
          res.interrupt    = 1'b1;
        end else begin
          previous_length_next = item.dma_length;
          // A pending secondary folds into the primary with the overlap adjustment.
          if (secondary_bytes != '0) begin
            if (secondary_bytes > primary_bytes) begin
              primary_address_next = secondary_address
                                     + adbr_pkg::ADDR_W'(secondary_bytes - primary_bytes);
            end else begin
              primary_address_next = secondary_address;
              primary_bytes_next   = secondary_bytes;
            end
          end
          secondary_address_next = item.dma_address;
          secondary_bytes_next   = item.dma_length;
          if (primary_bytes_next == '0) begin
            primary_address_next   = item.dma_address;
            primary_bytes_next     = item.dma_length;
            secondary_address_next = '0;
            secondary_bytes_next   = '0;
          end
          if (ai_emulation) begin
            status_busy_next = 1'b1;
            status_full_next = (primary_bytes_next != '0) && (secondary_bytes_next != '0);
          end
        end
      end

      adbr_pkg::MODE_DMA_WORD: begin
        if (fetch_now) begin
          ram_req.we     = accept;
          res.word_taken = 1'b1;
          write_index_next = (write_inc >= {1'b0, cap_words}) ? '0
                             : write_inc[adbr_pkg::RING_AW-1:0];
          fill_level_next      = fill_level + adbr_pkg::FILL_W'(4);
          primary_address_next = primary_address + adbr_pkg::ADDR_W'(4);
          primary_bytes_next   = (primary_bytes <= adbr_pkg::LEN_W'(4)) ? '0
                                 : primary_bytes - adbr_pkg::LEN_W'(4);
          // Primary exhausted: promote the secondary.
          if (primary_bytes_next == '0) begin
            primary_address_next   = secondary_address;
            primary_bytes_next     = secondary_bytes;
            secondary_address_next = '0;
            secondary_bytes_next   = '0;
            if (ai_emulation) begin
              tracked_length_next = '0;
              tracked_count_next  = '0;
              status_busy_next    = (secondary_bytes != '0);
              status_full_next    = 1'b0;
              res.interrupt       = 1'b1;
            end
          end
        end
      end

      adbr_pkg::MODE_PLAY: begin
        if (dma_on && (want_bytes <= cap_bytes)) begin
          if (item.request_first) begin
            request_granted_next = (want_bytes <= fill_level);
          end
          if (item.request_frames == '0) begin
            res.src = adbr_pkg::SRC_HELD;
          end else if (request_granted_next && (fill_level >= adbr_pkg::FILL_W'(4))) begin
            res.src         = adbr_pkg::SRC_RING;
            ram_req.re      = accept;
            read_index_next = (read_inc >= {1'b0, cap_words}) ? '0
                              : read_inc[adbr_pkg::RING_AW-1:0];
            fill_level_next = fill_level - adbr_pkg::FILL_W'(4);
          end else begin
            res.src      = adbr_pkg::SRC_HELD;
            res.underrun = 1'b1;
          end
        end
      end

      adbr_pkg::MODE_LEN_READ: begin
        if (ai_emulation && (previous_length != '0)) begin
          remain = ({5'b0, fill_level} > readback_limit) ? previous_length : primary_bytes;
          if (remain == tracked_length) begin
            // Same length seen again: report it one read step lower.
            if ({1'b0, remain} > read_step) begin
              tracked_count_next = tracked_count + 1'b1;
              remain = remain - {tracked_count_next, {adbr_pkg::STEP_SH{1'b0}}};
            end
          end else begin
            tracked_count_next  = '0;
            tracked_length_next = remain;
          end
          res.length_readback = {remain[adbr_pkg::LEN_W-1:3], 3'b000};
        end
      end

      default: begin
      end
    endcase

    res.ai_busy     = status_busy_next;
    res.fifo_full   = status_full_next;
    res.fetch_valid = dma_on && (fill_level_next < cap_bytes) && (primary_bytes_next != '0);
    res.fetch_address = res.fetch_valid ? primary_address_next : '0;
  end

  // State registers; a capacity write empties the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      dma_on            <= 1'b0;
      ai_emulation      <= 1'b1;
      ring_capacity     <= adbr_pkg::CAP_RESET;
      primary_address   <= '0;
      primary_bytes     <= '0;
      secondary_address <= '0;
      secondary_bytes   <= '0;
      write_index       <= '0;
      read_index        <= '0;
      fill_level        <= '0;
      previous_length   <= '0;
      tracked_length    <= '0;
      tracked_count     <= '0;
      request_granted   <= 1'b0;
      status_busy       <= 1'b0;
      status_full       <= 1'b0;
    end else begin
      if (accept) begin
        primary_address   <= primary_address_next;
        primary_bytes     <= primary_bytes_next;
        secondary_address <= secondary_address_next;
        secondary_bytes   <= secondary_bytes_next;
        write_index       <= write_index_next;
        read_index        <= read_index_next;
        fill_level        <= fill_level_next;
        previous_length   <= previous_length_next;
        tracked_length    <= tracked_length_next;
        tracked_count     <= tracked_count_next;
        request_granted   <= request_granted_next;
        status_busy       <= status_busy_next;
        status_full       <= status_full_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          adbr_pkg::CFG_DMA_ON: begin
            dma_on <= cfg_data[0];
          end
          adbr_pkg::CFG_AI_EMULATION: begin
            ai_emulation <= cfg_data[0];
          end
          adbr_pkg::CFG_CAPACITY: begin
            ring_capacity <= cfg_data;
            write_index   <= '0;
            read_index    <= '0;
            fill_level    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The ring never holds more than its capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= cap_bytes)
    else $error("ring fill level above capacity");

  // A ring read only happens when a word is stored.
  a_read_has_data: assert property (@(posedge clk) disable iff (rst)
    ram_req.re |-> (fill_level >= adbr_pkg::FILL_W'(4)))
    else $error("ring read while empty");

  // A word is only stored while the ring has room.
  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (fill_level < cap_bytes) && (primary_bytes != '0))
    else $error("ring write without room or descriptor");

  // Indexes stay inside the ring in use.
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, write_index} < {1'b0, cap_words}) && ({1'b0, read_index} < {1'b0, cap_words}))
    else $error("ring index beyond capacity");

endmodule

// ===== design/adbr_ostage.sv =====
module adbr_ostage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  output logic                               accept,
  input  adbr_pkg::adbr_res_t                res,
  input  logic [adbr_pkg::WORD_W-1:0]        ram_rdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output adbr_pkg::adbr_out_t                out_data
);

  adbr_pkg::adbr_res_t         res_q;
  logic [adbr_pkg::WORD_W-1:0] held_sample;

  // A new word enters whenever the result register is free or being emptied.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  // The last sample read from the ring is kept for repeats.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_sample <= '0;
    end else if (out_valid && (res_q.src == adbr_pkg::SRC_RING)) begin
      held_sample <= ram_rdata;
    end
  end

  always_comb begin
    out_data.ai_busy         = res_q.ai_busy;
    out_data.fifo_full       = res_q.fifo_full;
    out_data.interrupt       = res_q.interrupt;
    out_data.fetch_valid     = res_q.fetch_valid;
    out_data.fetch_address   = res_q.fetch_address;
    out_data.word_taken      = res_q.word_taken;
    out_data.underrun        = res_q.underrun;
    out_data.length_readback = res_q.length_readback;
    case (res_q.src)
      adbr_pkg::SRC_RING: out_data.play_sample = ram_rdata;
      adbr_pkg::SRC_HELD: out_data.play_sample = held_sample;
      default:            out_data.play_sample = '0;
    endcase
  end

endmodule

// ===== design/audio_dma_double_buffer_ring_top.sv =====
// Audio DMA front end with a primary/secondary descriptor pair feeding a
// 4096-word sample ring. Each input word (length write, DMA word, playback
// frame or length read) gives exactly one result word, registered in the cycle
// after acceptance; a new input word is taken every cycle, so the block
// sustains one word per clock as long as the output side does not stall.
// The single-port-write, single-port-read ring memory sets that figure: each
// word writes or reads at most one ring entry. Ring contents are not cleared
// at reset; the fill level alone tracks which entries hold data. Write the
// configuration registers (0 dma_on, 1 ai_emulation, 2 ring capacity in
// bytes) only while no result is outstanding; a capacity write empties the ring.
module audio_dma_double_buffer_ring_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  adbr_pkg::adbr_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output adbr_pkg::adbr_out_t                out_data,
  input  logic                               cfg_write,
  input  logic [adbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adbr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                        accept;
  adbr_pkg::adbr_ram_req_t     ram_req;
  adbr_pkg::adbr_res_t         res;
  logic [adbr_pkg::WORD_W-1:0] ram_rdata;

  // Descriptor, ring pointer and status logic
  adbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_req   (ram_req),
    .res       (res)
  );

  // Sample ring storage
  adbr_ram #(
    .DEPTH (adbr_pkg::RING_WORDS),
    .WIDTH (adbr_pkg::WORD_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Result register and held sample
  adbr_ostage u_ostage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accept    (accept),
    .res       (res),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 20;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  adbr_pkg::adbr_in_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  adbr_pkg::adbr_out_t             out_data;
  logic                            cfg_write = 1'b0;
  logic [adbr_pkg::CFG_IDX_W-1:0]  cfg_index = adbr_pkg::CFG_DMA_ON;
  logic [adbr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  audio_dma_double_buffer_ring_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the configuration registers, at their reset values.
  bit                         dma_on_q = 1'b0;
  bit                         emul_q   = 1'b1;
  logic [adbr_pkg::CAP_W-1:0] cap_q    = adbr_pkg::CAP_RESET;

  // Shadow of the descriptor pair, the sample ring and the readback tracker.
  logic [adbr_pkg::ADDR_W-1:0]  prim_addr  = '0;
  logic [adbr_pkg::LEN_W-1:0]   prim_len   = '0;
  logic [adbr_pkg::ADDR_W-1:0]  sec_addr   = '0;
  logic [adbr_pkg::LEN_W-1:0]   sec_len    = '0;
  logic [adbr_pkg::WORD_W-1:0]  ring_mem [adbr_pkg::RING_WORDS];
  logic [adbr_pkg::RING_AW-1:0] wr_ptr     = '0;
  logic [adbr_pkg::RING_AW-1:0] rd_ptr     = '0;
  logic [adbr_pkg::FILL_W-1:0]  fill_bytes = '0;
  logic [adbr_pkg::LEN_W-1:0]   last_len   = '0;
  logic [adbr_pkg::LEN_W-1:0]   track_len  = '0;
  logic [adbr_pkg::CNT_W-1:0]   track_cnt  = '0;
  logic [adbr_pkg::WORD_W-1:0]  held       = '0;
  bit                           granted    = 1'b0;
  bit                           busy       = 1'b0;
  bit                           full       = 1'b0;

  adbr_pkg::adbr_out_t expected_q [$];

  int unsigned mismatches = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_stored   = 0;
  int unsigned n_under    = 0;
  int unsigned n_irq      = 0;

  bit sender_idles  = 1'b1;
  bit quiet_tail    = 1'b0;
  bit long_hold_req = 1'b0;

  // Ring size in use: low two bits dropped, then clamped to the memory.
  function automatic int unsigned ring_bytes();
    int unsigned c;
    c = 32'(cap_q) & 32'h7FFC;
    if (c < 4) c = 4;
    if (c > adbr_pkg::RING_WORDS * 4) c = adbr_pkg::RING_WORDS * 4;
    return c;
  endfunction

  function automatic bit fetch_wanted();
    return dma_on_q && (32'(fill_bytes) < ring_bytes()) && (prim_len != 0);
  endfunction

  function automatic logic [adbr_pkg::RING_AW-1:0] next_slot(int unsigned i);
    int unsigned n;
    n = i + 1;
    return (n >= ring_bytes() / 4) ? '0 : adbr_pkg::RING_AW'(n);
  endfunction

  // Secondary descriptor moves up into the primary slot.
  function automatic void promote_secondary();
    prim_addr = sec_addr;
    prim_len  = sec_len;
    sec_addr  = '0;
    sec_len   = '0;
  endfunction

  // Applies one accepted word to the shadow state and returns its result.
  function automatic adbr_pkg::adbr_out_t ring_result(adbr_pkg::adbr_in_t w);
    adbr_pkg::adbr_out_t r;
    int unsigned         want;
    int unsigned         rb;
    r = '0;
    case (w.mode)
      adbr_pkg::MODE_LEN_WRITE: begin
        if (w.dma_length == 0) begin
          busy        = 1'b0;
          full        = 1'b0;
          r.interrupt = 1'b1;
        end else begin
          last_len = w.dma_length;
          // A pending secondary is folded into the primary first.
          if (sec_len != 0) begin
            if (sec_len > prim_len) begin
              prim_addr = sec_addr + adbr_pkg::ADDR_W'(sec_len - prim_len);
            end else begin
              prim_addr = sec_addr;
              prim_len  = sec_len;
            end
            sec_addr = '0;
            sec_len  = '0;
          end
          sec_addr = w.dma_address;
          sec_len  = w.dma_length;
          if (prim_len == 0) promote_secondary();
          if (emul_q) begin
            busy = 1'b1;
            full = (prim_len != 0) && (sec_len != 0);
          end
        end
      end
      adbr_pkg::MODE_DMA_WORD: begin
        if (fetch_wanted()) begin
          ring_mem[wr_ptr] = {w.dma_word[15:0], w.dma_word[31:16]};
          wr_ptr       = next_slot(32'(wr_ptr));
          fill_bytes   = fill_bytes + adbr_pkg::FILL_W'(4);
          prim_addr    = prim_addr + adbr_pkg::ADDR_W'(4);
          prim_len     = (prim_len <= adbr_pkg::LEN_W'(4)) ? '0
                         : prim_len - adbr_pkg::LEN_W'(4);
          r.word_taken = 1'b1;
          n_stored++;
          if (prim_len == 0) begin
            promote_secondary();
            if (emul_q) begin
              track_len   = '0;
              track_cnt   = '0;
              busy        = (prim_len != 0);
              full        = 1'b0;
              r.interrupt = 1'b1;
            end
          end
        end
      end
      adbr_pkg::MODE_PLAY: begin
        want = 32'(w.request_frames) * 4;
        if (!dma_on_q || want > ring_bytes()) begin
          r.play_sample = '0;
        end else begin
          if (w.request_first) granted = (want <= 32'(fill_bytes));
          if (w.request_frames == 0) begin
            r.play_sample = held;
          end else if (granted && fill_bytes >= adbr_pkg::FILL_W'(4)) begin
            held          = ring_mem[rd_ptr];
            r.play_sample = held;
            rd_ptr        = next_slot(32'(rd_ptr));
            fill_bytes    = fill_bytes - adbr_pkg::FILL_W'(4);
          end else begin
            r.play_sample = held;
            r.underrun    = 1'b1;
            n_under++;
          end
        end
      end
      adbr_pkg::MODE_LEN_READ: begin
        if (emul_q && last_len != 0) begin
          if (32'(fill_bytes) > 32'(last_len) * 2 + 32'(last_len) / 4) rb = 32'(last_len);
          else rb = 32'(prim_len);
          // Repeated reads of the same length decay in steps of 32 bytes.
          if (rb == 32'(track_len)) begin
            if (rb > 32 * (32'(track_cnt) + 1)) begin
              track_cnt = track_cnt + 1'b1;
              rb = rb - 32 * 32'(track_cnt);
            end
          end else begin
            track_cnt = '0;
            track_len = adbr_pkg::LEN_W'(rb);
          end
          r.length_readback = adbr_pkg::LEN_W'(rb & 32'h3FFF8);
        end
      end
      default: ;
    endcase
    r.ai_busy   = busy;
    r.fifo_full = full;
    if (fetch_wanted()) begin
      r.fetch_valid   = 1'b1;
      r.fetch_address = prim_addr;
    end
    if (r.interrupt) n_irq++;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Register writes and accepted words feed the shadow; results are checked in order.
  always @(posedge clk) begin
    adbr_pkg::adbr_out_t want_res;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          adbr_pkg::CFG_DMA_ON:       dma_on_q = cfg_data[0];
          adbr_pkg::CFG_AI_EMULATION: emul_q   = cfg_data[0];
          adbr_pkg::CFG_CAPACITY: begin
            cap_q      = cfg_data;
            wr_ptr     = '0;
            rd_ptr     = '0;
            fill_bytes = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(ring_result(in_data));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no word pending, expected none got %h", $time, out_data);
          mismatches++;
        end else begin
          want_res = expected_q.pop_front();
          compare_field("ai_busy", 32'(want_res.ai_busy), 32'(out_data.ai_busy));
          compare_field("fifo_full", 32'(want_res.fifo_full), 32'(out_data.fifo_full));
          compare_field("interrupt", 32'(want_res.interrupt), 32'(out_data.interrupt));
          compare_field("fetch_valid", 32'(want_res.fetch_valid),
                        32'(out_data.fetch_valid));
          compare_field("fetch_address", 32'(want_res.fetch_address),
                        32'(out_data.fetch_address));
          compare_field("word_taken", 32'(want_res.word_taken), 32'(out_data.word_taken));
          compare_field("play_sample", want_res.play_sample, out_data.play_sample);
          compare_field("underrun", 32'(want_res.underrun), 32'(out_data.underrun));
          compare_field("length_readback", 32'(want_res.length_readback),
                        32'(out_data.length_readback));
          n_checked++;
        end
      end
    end
  end

  // Output side: random stall bursts, one long hold on request, none at the end.
  initial begin
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Offers one word and returns at the edge that accepts it.
  task automatic send_word(adbr_pkg::adbr_in_t w);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A word of the given mode with random content in every field.
  function automatic adbr_pkg::adbr_in_t random_word(adbr_pkg::mode_t m);
    adbr_pkg::adbr_in_t w;
    w.mode           = m;
    w.dma_address    = adbr_pkg::ADDR_W'($urandom);
    w.dma_length     = adbr_pkg::LEN_W'($urandom);
    w.dma_word       = $urandom;
    w.request_first  = ($urandom_range(0, 1) != 0);
    w.request_frames = adbr_pkg::FRAMES_W'($urandom_range(0, 4096));
    return w;
  endfunction

  task automatic len_write(logic [adbr_pkg::ADDR_W-1:0] addr, logic [adbr_pkg::LEN_W-1:0] len);
    adbr_pkg::adbr_in_t w;
    w = random_word(adbr_pkg::MODE_LEN_WRITE);
    w.dma_address = addr;
    w.dma_length  = len;
    send_word(w);
  endtask

  task automatic dma_word(logic [adbr_pkg::WORD_W-1:0] data);
    adbr_pkg::adbr_in_t w;
    w = random_word(adbr_pkg::MODE_DMA_WORD);
    w.dma_word = data;
    send_word(w);
  endtask

  task automatic len_read();
    send_word(random_word(adbr_pkg::MODE_LEN_READ));
  endtask

  // Sends n frames of one playback request; only the first may carry the start mark.
  task automatic play_request(int unsigned frames, int unsigned n, bit first);
    adbr_pkg::adbr_in_t w;
    for (int unsigned i = 0; i < n; i++) begin
      w = random_word(adbr_pkg::MODE_PLAY);
      w.request_frames = adbr_pkg::FRAMES_W'(frames);
      w.request_first  = (i == 0) ? first : 1'b0;
      send_word(w);
    end
  endtask

  // Drops valid and waits until every result has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [adbr_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= adbr_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(bit dma_on, bit emul, int unsigned cap);
    wait_drained();
    write_reg(adbr_pkg::CFG_DMA_ON, 32'(dma_on));
    write_reg(adbr_pkg::CFG_AI_EMULATION, 32'(emul));
    write_reg(adbr_pkg::CFG_CAPACITY, cap);
  endtask

  // Mostly DMA words and playback requests, some descriptor writes and length reads;
  // some requests are cut short, overrun or start without the start mark.
  task automatic random_traffic(int unsigned count, int unsigned max_len);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned frames;
    int unsigned n;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        len = $urandom_range(1, max_len);
        case ($urandom_range(0, 19))
          0:          len = 0;
          1:          len = $urandom_range(0, 262143);
          2, 3, 4, 5: ;
          default:    len = (len + 3) & ~32'd3;
        endcase
        len_write(adbr_pkg::ADDR_W'($urandom), adbr_pkg::LEN_W'(len));
        sent++;
      end else if (pick < 55) begin
        dma_word($urandom);
        sent++;
      end else if (pick < 85) begin
        case ($urandom_range(0, 19))
          0:       frames = $urandom_range(0, 4096);
          1, 2, 3: frames = $urandom_range(0, ring_bytes() / 4 + 2);
          default: frames = $urandom_range(0, 8);
        endcase
        n = (frames == 0) ? 1 : ((frames > 8) ? $urandom_range(1, 8) : frames);
        if ($urandom_range(0, 9) == 0) n = n + 1;
        play_request(frames, n, $urandom_range(0, 19) != 0);
        sent += n;
      end else begin
        len_read();
        sent++;
      end
    end
  endtask

  // Right after reset DMA is off: nothing fetched, silent playback, zero readback.
  task automatic test_after_reset();
    len_read();
    play_request(1, 1, 1'b1);
    dma_word($urandom);
    len_write(24'h123456, '0);
  endtask

  // Descriptor chaining, address wrap, odd lengths, drain, underrun and readback decay.
  task automatic test_directed();
    set_config(1'b1, 1'b1, 64);
    len_write(24'hFFFFFC, 18'd12);
    len_write(24'h000100, 18'd6);
    dma_word(32'hFFFFFFFF);
    dma_word(32'h00000000);
    dma_word(32'h12345678);
    len_read();
    dma_word(32'hABCD0001);
    dma_word(32'h8000FFFF);
    play_request(0, 1, 1'b1);
    play_request(3, 3, 1'b1);
    play_request(20, 1, 1'b1);
    play_request(4, 1, 1'b1);
    len_read();
    len_write(24'hFFFFFF, 18'h3FFFF);
    len_read();
    len_read();
    len_write(24'h000000, '0);
    dma_word($urandom);
  endtask

  // Capacity values below, above and between the legal sizes.
  task automatic test_capacity_limits();
    int unsigned caps [4];
    caps = '{0, 3, 32767, 66};
    foreach (caps[i]) begin
      wait_drained();
      write_reg(adbr_pkg::CFG_CAPACITY, caps[i]);
      random_traffic(12, 64);
    end
  endtask

  task automatic test_random_phases();
    set_config(1'b1, 1'b1, 64);
    random_traffic(300, 96);
    set_config(1'b1, 1'b0, 128);
    random_traffic(200, 128);
    set_config(1'b1, 1'b1, 4);
    random_traffic(150, 32);
    set_config(1'b0, 1'b1, 128);
    random_traffic(80, 64);
    set_config(1'b1, 1'b1, 4 * $urandom_range(2, 128));
    random_traffic(200, 256);
  endtask

  // The output side holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    set_config(1'b1, 1'b1, 256);
    sender_idles  = 1'b0;
    long_hold_req = 1'b1;
    random_traffic(80, 128);
    sender_idles  = 1'b1;
  endtask

  // The input side pauses until every result has come back.
  task automatic test_sender_pause();
    random_traffic(40, 64);
    wait_drained();
    random_traffic(40, 64);
  endtask

  // Largest ring, no idling on either side.
  task automatic test_quiet_tail();
    set_config(1'b1, 1'b1, 16384);
    quiet_tail   = 1'b1;
    sender_idles = 1'b0;
    random_traffic(250, 256);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_directed();
    test_capacity_limits();
    test_random_phases();
    test_backpressure();
    test_sender_pause();
    test_quiet_tail();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words, compared %0d results: %0d ring stores, %0d underruns, %0d irqs.",
             n_accepted, n_checked, n_stored, n_under, n_irq);
    $display("Ring sizes 4 to 16384 bytes, DMA on and off, status emulation on and off.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results still pending.", expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/adbr_pkg.sv
design/adbr_ram.sv
design/adbr_ctrl.sv
design/adbr_ostage.sv
design/audio_dma_double_buffer_ring_top.sv
tb/tb_top.sv
